>>> rtl/bcd_pkg.sv
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types and constants for the budgeted chunk deque: operation codes,
// register indexes, item structs and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bcd_pkg;

	typedef enum logic [2:0] {
		OP_APPEND     = 3'd0,
		OP_PREPEND    = 3'd1,
		OP_EVICT_HEAD = 3'd2,
		OP_EVICT_TAIL = 3'd3,
		OP_CLEAR      = 3'd4,
		OP_MARK_START = 3'd5,
		OP_MARK_END   = 3'd6
	} op_e;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAD = 2'd1;

	localparam logic [19:0] CAPACITY_RESET = 20'd8192;
	localparam logic [7:0]  OVERHEAD_RESET = 8'd20;

	localparam logic [23:0] CHARGED_MAX = 24'hFFFFFF;
	localparam logic [21:0] TEXT_MAX    = 22'h3FFFFF;
	localparam logic [6:0]  EVICT_MAX   = 7'd127;

	typedef struct packed {
		logic [2:0]  op;
		logic [30:0] chunk_offset;
		logic [15:0] chunk_length;
	} in_item_t;

	typedef struct packed {
		logic               accepted;
		logic [6:0]         evicted_count;
		logic signed [31:0] head_offset;
		logic [31:0]        tail_end_offset;
		logic [23:0]        used_bytes;
		logic [21:0]        text_bytes;
		logic [6:0]         chunk_count;
		logic               start_reached;
		logic               end_reached;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic set_accept;
		logic evict;
		logic evict_head;
		logic write;
		logic clear;
		logic mark_start;
		logic mark_end;
		logic rd_tail;
		logic cap_head;
		logic finish;
	} dq_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       len_zero;
		logic       empty;
		logic       need_evict;
	} dq_status_t;

endpackage

>>> rtl/bcd_ram.sv
// ----------------------------------------------------------------------------
// bcd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bcd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/bcd_ctrl.sv
// ----------------------------------------------------------------------------
// bcd_ctrl
// Sequencer for the chunk deque: decodes the operation, runs the eviction
// loop one chunk at a time, writes the new chunk and reads back head and tail.
// ----------------------------------------------------------------------------
module bcd_ctrl import bcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dq_status_t st,
	output dq_cmd_t    cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CHECK,
		ST_EVICT,
		ST_WRITE,
		ST_RD_HEAD,
		ST_RD_TAIL,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   done_q;
	logic   victim_head;
	logic   is_add;

	assign victim_head = (st.op == OP_APPEND) || (st.op == OP_EVICT_HEAD);
	assign is_add      = (st.op == OP_APPEND) || (st.op == OP_PREPEND);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && !busy_q) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_RD_HEAD;
				case (st.op)
					OP_APPEND, OP_PREPEND: begin
						if (!st.len_zero) begin
							cmd.set_accept = 1'b1;
							state_d        = ST_CHECK;
						end
					end
					OP_EVICT_HEAD, OP_EVICT_TAIL: begin
						cmd.rd_tail = !victim_head;
						if (!st.empty) begin
							cmd.set_accept = 1'b1;
							state_d        = ST_EVICT;
						end
					end
					OP_CLEAR: begin
						cmd.clear      = 1'b1;
						cmd.set_accept = 1'b1;
					end
					OP_MARK_START: begin
						cmd.mark_start = 1'b1;
						cmd.set_accept = 1'b1;
					end
					OP_MARK_END: begin
						cmd.mark_end   = 1'b1;
						cmd.set_accept = 1'b1;
					end
					default: begin
						state_d = ST_RD_HEAD;
					end
				endcase
			end
			ST_CHECK: begin
				cmd.rd_tail = !victim_head;
				state_d     = st.need_evict ? ST_EVICT : ST_WRITE;
			end
			ST_EVICT: begin
				cmd.evict      = 1'b1;
				cmd.evict_head = victim_head;
				state_d        = is_add ? ST_CHECK : ST_RD_HEAD;
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_d   = ST_RD_HEAD;
			end
			ST_RD_HEAD: begin
				state_d = ST_RD_TAIL;
			end
			ST_RD_TAIL: begin
				cmd.rd_tail  = 1'b1;
				cmd.cap_head = 1'b1;
				state_d      = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
			done_q  <= (state_q == ST_FINISH);
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	a_busy_while_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> busy_q)
		else $error("controller active while not busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	a_evict_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVICT) |-> !st.empty)
		else $error("eviction issued on an empty deque");

endmodule

>>> rtl/bcd_dp.sv
// ----------------------------------------------------------------------------
// bcd_dp
// Datapath for the chunk deque: descriptor RAMs, ring pointers, saturating
// byte totals, flags, configuration registers and the result register.
// ----------------------------------------------------------------------------
module bcd_dp import bcd_pkg::*; #(
	parameter int MAX_CHUNKS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_item_t              item,
	input  dq_cmd_t               cmd,
	output dq_status_t            st,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output out_item_t             result
);

	localparam int SLOT_W = $clog2(MAX_CHUNKS);
	localparam int SW1    = SLOT_W + 1;
	localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);

	// captured operation
	logic [2:0]  op_q;
	logic [30:0] off_q;
	logic [15:0] len_q;
	logic [16:0] cost_q;

	// deque state
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	logic [23:0]       charged_q;
	logic [21:0]       text_q;
	logic              start_q;
	logic              end_q;
	logic [19:0]       cap_q;
	logic [7:0]        ovh_q;

	logic        accepted_q;
	logic [6:0]  ev_q;
	logic [30:0] head_off_q;
	out_item_t   result_q;

	logic [SLOT_W-1:0] head_inc;
	logic [SLOT_W-1:0] head_dec;
	logic [SW1-1:0]    tail_sum;
	logic [SW1-1:0]    app_sum;
	logic [SLOT_W-1:0] tail_slot;
	logic [SLOT_W-1:0] app_slot;
	logic [SLOT_W-1:0] raddr;
	logic [SLOT_W-1:0] waddr;
	logic [30:0]       off_rd;
	logic [15:0]       len_rd;
	logic [24:0]       need_sum;
	logic [16:0]       drop_cost;
	logic [24:0]       add_charged;
	logic [22:0]       add_text;
	logic [31:0]       count32;
	logic              write_tail;

	assign head_inc = (head_q == SLOT_W'(MAX_CHUNKS - 1)) ? '0 : head_q + SLOT_W'(1);
	assign head_dec = (head_q == '0) ? SLOT_W'(MAX_CHUNKS - 1) : head_q - SLOT_W'(1);

	assign tail_sum  = SW1'(head_q) + SW1'(count_q) - SW1'(1);
	assign app_sum   = SW1'(head_q) + SW1'(count_q);
	assign tail_slot = (tail_sum >= SW1'(MAX_CHUNKS)) ?
		SLOT_W'(tail_sum - SW1'(MAX_CHUNKS)) : SLOT_W'(tail_sum);
	assign app_slot  = (app_sum >= SW1'(MAX_CHUNKS)) ?
		SLOT_W'(app_sum - SW1'(MAX_CHUNKS)) : SLOT_W'(app_sum);

	assign write_tail = (op_q == OP_APPEND);
	assign raddr      = cmd.rd_tail ? tail_slot : head_q;
	assign waddr      = write_tail ? app_slot : head_dec;

	bcd_ram #(.WIDTH(31), .DEPTH(MAX_CHUNKS)) u_off_ram (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (waddr),
		.wdata (off_q),
		.raddr (raddr),
		.rdata (off_rd)
	);

	bcd_ram #(.WIDTH(16), .DEPTH(MAX_CHUNKS)) u_len_ram (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (waddr),
		.wdata (len_q),
		.raddr (raddr),
		.rdata (len_rd)
	);

	assign need_sum    = 25'(charged_q) + 25'(cost_q);
	assign drop_cost   = 17'(len_rd) + 17'(ovh_q);
	assign add_charged = 25'(charged_q) + 25'(cost_q);
	assign add_text    = 23'(text_q) + 23'(len_q);
	assign count32     = 32'(count_q);

	assign st.op         = op_q;
	assign st.len_zero   = (len_q == '0);
	assign st.empty      = (count_q == '0);
	assign st.need_evict = (count_q != '0) &&
		((need_sum > 25'(cap_q)) || (count_q >= CNT_W'(MAX_CHUNKS)));

	// operation capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= item.op;
			off_q  <= item.chunk_offset;
			len_q  <= item.chunk_length;
			cost_q <= 17'(item.chunk_length) + 17'(ovh_q);
		end
		if (cmd.cap_head) begin
			head_off_q <= off_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			charged_q  <= '0;
			text_q     <= '0;
			start_q    <= 1'b0;
			end_q      <= 1'b0;
			cap_q      <= CAPACITY_RESET;
			ovh_q      <= OVERHEAD_RESET;
			accepted_q <= 1'b0;
			ev_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CAPACITY: cap_q <= cfg_data[19:0];
					CFG_OVERHEAD: ovh_q <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
			if (cmd.capture) begin
				accepted_q <= 1'b0;
				ev_q       <= '0;
			end
			if (cmd.set_accept) begin
				accepted_q <= 1'b1;
			end
			if (cmd.evict) begin
				charged_q <= (charged_q > 24'(drop_cost)) ? charged_q - 24'(drop_cost) : '0;
				text_q    <= (text_q > 22'(len_rd)) ? text_q - 22'(len_rd) : '0;
				count_q   <= count_q - CNT_W'(1);
				ev_q      <= (ev_q == EVICT_MAX) ? ev_q : ev_q + 7'd1;
				if (cmd.evict_head) begin
					head_q  <= head_inc;
					start_q <= 1'b0;
				end else begin
					end_q <= 1'b0;
				end
			end
			if (cmd.write) begin
				if (!write_tail) begin
					head_q <= head_dec;
				end
				count_q   <= count_q + CNT_W'(1);
				charged_q <= (add_charged > 25'(CHARGED_MAX)) ? CHARGED_MAX : add_charged[23:0];
				text_q    <= (add_text > 23'(TEXT_MAX)) ? TEXT_MAX : add_text[21:0];
			end
			if (cmd.clear) begin
				ev_q      <= (count32 > 32'(EVICT_MAX)) ? EVICT_MAX : count32[6:0];
				count_q   <= '0;
				head_q    <= '0;
				charged_q <= '0;
				text_q    <= '0;
				start_q   <= 1'b0;
				end_q     <= 1'b0;
			end
			if (cmd.mark_start) begin
				start_q <= 1'b1;
			end
			if (cmd.mark_end) begin
				end_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.accepted      <= accepted_q;
			result_q.evicted_count <= ev_q;
			if (count_q == '0) begin
				result_q.head_offset     <= -32'sd1;
				result_q.tail_end_offset <= '0;
			end else begin
				result_q.head_offset     <= signed'({1'b0, head_off_q});
				result_q.tail_end_offset <= 32'(off_rd) + 32'(len_rd);
			end
			result_q.used_bytes    <= charged_q;
			result_q.text_bytes    <= text_q;
			result_q.chunk_count   <= count32[6:0];
			result_q.start_reached <= start_q;
			result_q.end_reached   <= end_q;
		end
	end

	assign result = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_CHUNKS))
		else $error("chunk count above store depth");

	a_write_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> (count_q < CNT_W'(MAX_CHUNKS)))
		else $error("descriptor write into a full store");

endmodule

>>> rtl/budgeted_chunk_deque_top.sv
// results: each op passes decode, head read, tail read, finish; an eviction adds the
// evict state, an add the check, an evict and a check per victim, and the write
// each eviction is a read of the length RAM followed by a subtract of the totals
// a new start is taken in the cycle that the result strobe is high
// async reset clears pointers, totals, flags; capacity 8192, overhead 20
// descriptor RAM contents are undefined after reset; no clearing pass
// ----------------------------------------------------------------------------
// budgeted_chunk_deque_top
// Double-ended queue of chunk descriptors kept under a byte budget, with
// eviction from the opposite end on add and a configuration write channel.
// ----------------------------------------------------------------------------
module budgeted_chunk_deque_top import bcd_pkg::*; #(
	parameter int MAX_CHUNKS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_item_t              item,
	output logic                  done,
	output out_item_t             result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dq_cmd_t    cmd;
	dq_status_t st;
	logic       busy_w;

	bcd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy_w),
		.done   (done)
	);

	bcd_dp #(.MAX_CHUNKS(MAX_CHUNKS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.st        (st),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

	assign busy      = busy_w;
	assign cfg_ready = ~busy_w & ~start;

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the budgeted chunk deque. Commands go in through the
// start/busy port and one status result per command is checked field by
// field against an in-bench model of the deque. The run steps through
// several budget and overhead settings, the extremes among them.
// ----------------------------------------------------------------------------
module testbench import bcd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          DEPTH           = 64;
	localparam int          PHASES          = 10;
	localparam int          ITEMS_PER_PHASE = 195;
	localparam longint      LIMIT_CYCLES    = 2000000;
	localparam logic [2:0]  OP_UNUSED       = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	in_item_t              item = '0;
	logic                  done;
	out_item_t             result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	budgeted_chunk_deque_top #(
		.MAX_CHUNKS(DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// deque model state
	int unsigned cfg_capacity = CAPACITY_RESET;
	int unsigned cfg_overhead = OVERHEAD_RESET;
	logic [30:0] dq_off [DEPTH];
	logic [15:0] dq_len [DEPTH];
	int unsigned dq_head = 0;
	int unsigned dq_count = 0;
	int unsigned dq_charged = 0;
	int unsigned dq_text = 0;
	logic        dq_start_flag = 1'b0;
	logic        dq_end_flag = 1'b0;

	in_item_t  pending_ops [$];
	out_item_t expected_status [$];

	int     gap_left = 0;
	int     burst_left = 0;
	int     mismatches = 0;
	int     n_accepted = 0;
	int     n_results = 0;
	int     n_evicted = 0;
	int     n_rejected = 0;
	longint cycles = 0;

	function automatic int unsigned sat_add(input int unsigned a, input int unsigned b,
			input int unsigned max);
		longint unsigned s;
		s = longint'(a) + longint'(b);
		return (s > max) ? max : int'(s);
	endfunction

	function automatic int unsigned floor_sub(input int unsigned a, input int unsigned b);
		return (a > b) ? a - b : 0;
	endfunction

	function automatic int unsigned tail_idx();
		return (dq_head + dq_count + DEPTH - 1) % DEPTH;
	endfunction

	function automatic int unsigned evict_chunk(input bit take_head);
		int unsigned slot;
		if (dq_count == 0)
			return 0;
		slot = take_head ? dq_head : tail_idx();
		dq_charged = floor_sub(dq_charged, dq_len[slot] + cfg_overhead);
		dq_text = floor_sub(dq_text, dq_len[slot]);
		dq_count--;
		if (take_head) begin
			dq_head = (dq_head + 1) % DEPTH;
			dq_start_flag = 1'b0;
		end else begin
			dq_end_flag = 1'b0;
		end
		return 1;
	endfunction

	function automatic int unsigned add_chunk(input bit at_tail, input logic [30:0] off,
			input logic [15:0] len);
		int unsigned cost;
		int unsigned ev;
		int unsigned slot;
		cost = len + cfg_overhead;
		ev = 0;
		while (dq_count > 0 && (dq_charged + cost > cfg_capacity || dq_count >= DEPTH))
			ev += evict_chunk(at_tail);
		if (at_tail) begin
			slot = (dq_head + dq_count) % DEPTH;
		end else begin
			dq_head = (dq_head + DEPTH - 1) % DEPTH;
			slot = dq_head;
		end
		dq_off[slot] = off;
		dq_len[slot] = len;
		dq_count++;
		dq_charged = sat_add(dq_charged, cost, CHARGED_MAX);
		dq_text = sat_add(dq_text, len, TEXT_MAX);
		return ev;
	endfunction

	task automatic apply_deque_op(input in_item_t it);
		out_item_t   st;
		int unsigned ev;
		int unsigned t;
		logic        ok;
		ev = 0;
		ok = 1'b0;
		case (it.op)
			OP_APPEND, OP_PREPEND: begin
				if (it.chunk_length != 0) begin
					ev = add_chunk(it.op == OP_APPEND, it.chunk_offset, it.chunk_length);
					ok = 1'b1;
				end
			end
			OP_EVICT_HEAD, OP_EVICT_TAIL: begin
				ev = evict_chunk(it.op == OP_EVICT_HEAD);
				ok = (ev != 0);
			end
			OP_CLEAR: begin
				ev = dq_count;
				dq_count = 0;
				dq_head = 0;
				dq_charged = 0;
				dq_text = 0;
				dq_start_flag = 1'b0;
				dq_end_flag = 1'b0;
				ok = 1'b1;
			end
			OP_MARK_START: begin
				dq_start_flag = 1'b1;
				ok = 1'b1;
			end
			OP_MARK_END: begin
				dq_end_flag = 1'b1;
				ok = 1'b1;
			end
			default: begin
			end
		endcase
		st.accepted = ok;
		st.evicted_count = (ev > EVICT_MAX) ? EVICT_MAX : 7'(ev);
		if (dq_count == 0) begin
			st.head_offset = -32'sd1;
			st.tail_end_offset = '0;
		end else begin
			t = tail_idx();
			st.head_offset = {1'b0, dq_off[dq_head]};
			st.tail_end_offset = {1'b0, dq_off[t]} + 32'(dq_len[t]);
		end
		st.used_bytes = 24'(dq_charged);
		st.text_bytes = 22'(dq_text);
		st.chunk_count = 7'(dq_count);
		st.start_reached = dq_start_flag;
		st.end_reached = dq_end_flag;
		expected_status.push_back(st);
	endtask

	function automatic string status_diff(input out_item_t e, input out_item_t a);
		string s;
		s = "";
		if (a.accepted !== e.accepted)
			s = {s, $sformatf(" accepted exp %0d got %0d", e.accepted, a.accepted)};
		if (a.evicted_count !== e.evicted_count)
			s = {s, $sformatf(" evicted exp %0d got %0d", e.evicted_count, a.evicted_count)};
		if (a.head_offset !== e.head_offset)
			s = {s, $sformatf(" head exp %0d got %0d", e.head_offset, a.head_offset)};
		if (a.tail_end_offset !== e.tail_end_offset)
			s = {s, $sformatf(" tail_end exp %0h got %0h", e.tail_end_offset,
				a.tail_end_offset)};
		if (a.used_bytes !== e.used_bytes)
			s = {s, $sformatf(" used exp %0d got %0d", e.used_bytes, a.used_bytes)};
		if (a.text_bytes !== e.text_bytes)
			s = {s, $sformatf(" text exp %0d got %0d", e.text_bytes, a.text_bytes)};
		if (a.chunk_count !== e.chunk_count)
			s = {s, $sformatf(" count exp %0d got %0d", e.chunk_count, a.chunk_count)};
		if (a.start_reached !== e.start_reached)
			s = {s, $sformatf(" start exp %0d got %0d", e.start_reached, a.start_reached)};
		if (a.end_reached !== e.end_reached)
			s = {s, $sformatf(" end exp %0d got %0d", e.end_reached, a.end_reached)};
		return s;
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", msg);
	endtask

	function automatic int next_gap();
		int unsigned r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			burst_left = $urandom_range(20, 60);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 8);
		return $urandom_range(9, 60);
	endfunction

	function automatic in_item_t random_op(input int unsigned len_span);
		in_item_t    it;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 36)
			it.op = OP_APPEND;
		else if (r < 70)
			it.op = OP_PREPEND;
		else if (r < 78)
			it.op = OP_EVICT_HEAD;
		else if (r < 86)
			it.op = OP_EVICT_TAIL;
		else if (r < 88)
			it.op = OP_CLEAR;
		else if (r < 93)
			it.op = OP_MARK_START;
		else if (r < 98)
			it.op = OP_MARK_END;
		else
			it.op = OP_UNUSED;
		it.chunk_offset = 31'($urandom());
		r = $urandom_range(0, 99);
		if (r < 4)
			it.chunk_length = '0;
		else if (r < 62)
			it.chunk_length = 16'($urandom_range(1, len_span));
		else if (r < 88)
			it.chunk_length = 16'($urandom_range(1, 4000));
		else
			it.chunk_length = 16'($urandom());
		return it;
	endfunction

	task automatic queue_op(input logic [2:0] op, input logic [30:0] off,
			input logic [15:0] len);
		in_item_t it;
		it.op = op;
		it.chunk_offset = off;
		it.chunk_length = len;
		pending_ops.push_back(it);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_ops.size() != 0 || start || expected_status.size() != 0);
	endtask

	// caller is at a rising edge; returns at the edge of the transfer
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
	endtask

	// command driver
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && busy === 1'b0) begin
				apply_deque_op(item);
				n_accepted++;
				gap_left = next_gap();
			end
			if (!start || busy === 1'b0) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_ops.size() != 0) begin
					item <= pending_ops.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// status monitor
	always @(posedge clk) begin : monitor
		out_item_t want;
		string     diff;
		if (arst_n && done === 1'b1) begin
			n_results++;
			if (expected_status.size() == 0) begin
				note_mismatch($sformatf("unexpected result %0d, count %0d", n_results,
					result.chunk_count));
			end else begin
				want = expected_status.pop_front();
				diff = status_diff(want, result);
				if (diff != "")
					note_mismatch($sformatf("result %0d:%s", n_results, diff));
				n_evicted += result.evicted_count;
				if (!result.accepted)
					n_rejected++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("budgeted_chunk_deque_top test failed");
			$finish;
		end
	end

	initial begin
		int unsigned cap;
		int unsigned ov;
		int unsigned span;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			span = 64;
			if (p != 0) begin
				wait_drained();
				case (p)
					1: begin cap = 20'hFFFFF; ov = 0; end
					2: begin cap = 0; ov = 255; end
					3: begin cap = 20'hFFFFF; ov = 255; end
					4: begin cap = 300; ov = 0; end
					5: begin cap = CAPACITY_RESET; ov = OVERHEAD_RESET; end
					default: begin
						cap = $urandom_range(0, 1) ? $urandom_range(0, 20000)
							: $urandom_range(0, 20'hFFFFF);
						ov = $urandom_range(0, 255);
						span = $urandom_range(8, 2000);
					end
				endcase
				@(posedge clk);
				write_register(CFG_CAPACITY, CFG_DATA_W'(cap));
				write_register(CFG_OVERHEAD, CFG_DATA_W'(ov));
				cfg_valid <= 1'b0;
				cfg_capacity = cap;
				cfg_overhead = ov;
			end
			@(negedge clk);
			if (p == 0) begin
				queue_op(OP_EVICT_HEAD, 31'd0, 16'd0);
				queue_op(OP_EVICT_TAIL, 31'd0, 16'd0);
				queue_op(OP_APPEND, 31'd10, 16'd0);
				queue_op(OP_PREPEND, 31'd10, 16'd0);
				queue_op(OP_UNUSED, 31'd0, 16'd0);
				queue_op(OP_APPEND, 31'd0, 16'd1);
				queue_op(OP_APPEND, 31'h7FFFFFFF, 16'hFFFF);
				queue_op(OP_PREPEND, 31'd5, 16'd100);
				queue_op(OP_MARK_START, 31'd0, 16'd0);
				queue_op(OP_MARK_END, 31'd0, 16'd0);
				queue_op(OP_APPEND, 31'd105, 16'd8000);
				queue_op(OP_APPEND, 31'd8105, 16'd50);
				queue_op(OP_MARK_START, 31'd0, 16'd0);
				queue_op(OP_PREPEND, 31'd0, 16'd200);
				queue_op(OP_EVICT_TAIL, 31'd0, 16'd0);
				queue_op(OP_MARK_END, 31'd0, 16'd0);
				queue_op(OP_APPEND, 31'h7FFFFFFF, 16'hFFFF);
				queue_op(OP_CLEAR, 31'h7FFFFFFF, 16'hFFFF);
				queue_op(OP_UNUSED, 31'h7FFFFFFF, 16'hFFFF);
				queue_op(OP_MARK_START, 31'd0, 16'd0);
				queue_op(OP_EVICT_HEAD, 31'd0, 16'd0);
				queue_op(OP_EVICT_TAIL, 31'd0, 16'd0);
			end
			repeat (ITEMS_PER_PHASE)
				pending_ops.push_back(random_op(span));
		end
		wait_drained();
		repeat (150) @(posedge clk);
		$display("ran %0d commands under %0d budget settings, %0d results checked",
			n_accepted, PHASES, n_results);
		$display("%0d chunks evicted, %0d commands refused, %0d mismatches",
			n_evicted, n_rejected, mismatches);
		if (mismatches == 0 && expected_status.size() == 0) begin
			$display("budgeted_chunk_deque_top test passed");
		end else begin
			$display("budgeted_chunk_deque_top test failed");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/bcd_pkg.sv
rtl/bcd_ram.sv
rtl/bcd_ctrl.sv
rtl/bcd_dp.sv
rtl/budgeted_chunk_deque_top.sv
bench/testbench.sv
